@@ sv/pstg_pkg.sv @@
package pstg_pkg;

   localparam logic [15:0] OUT_RATE_RESET  = 16'd16000;
   localparam logic [15:0] TONE_FREQ_RESET = 16'd1000;
   localparam logic [6:0]  VOLUME_RESET    = 7'd100;

   localparam logic [6:0]  VOL_MAX   = 7'd100;
   localparam logic [16:0] AMP_FULL  = 17'd819;
   // floor(x / 100) == (x * AMP_RECIP) >> AMP_SHIFT for x <= 819 * 100
   localparam logic [16:0] AMP_RECIP = 17'd83887;
   localparam int          AMP_SHIFT = 23;

   localparam logic [1:0] REG_OUT_RATE  = 2'd0;
   localparam logic [1:0] REG_TONE_FREQ = 2'd1;
   localparam logic [1:0] REG_VOLUME    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL1,
      ST_MUL2,
      ST_DONE
   } pstg_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mul1;
      logic mul2;
      logic out_load;
   } pstg_cmd_type;

endpackage

@@ sv/pstg_csr.sv @@
module pstg_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] out_rate,
   output logic [15:0] tone_freq,
   output logic [6:0]  volume
);
   import pstg_pkg::*;

   logic [15:0] out_rate_ff, out_rate_in;
   logic [15:0] tone_freq_ff, tone_freq_in;
   logic [6:0]  volume_ff, volume_in;
   logic        wr_en;
   logic [1:0]  reg_sel;

   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[3:2];

   always_comb begin
      out_rate_in  = out_rate_ff;
      tone_freq_in = tone_freq_ff;
      volume_in    = volume_ff;
      csr_prdata   = 32'd0;
      case (reg_sel)
         REG_OUT_RATE: begin
            csr_prdata = {16'd0, out_rate_ff};
            if (wr_en) out_rate_in = csr_pwdata[15:0];
         end
         REG_TONE_FREQ: begin
            csr_prdata = {16'd0, tone_freq_ff};
            if (wr_en) tone_freq_in = csr_pwdata[15:0];
         end
         REG_VOLUME: begin
            csr_prdata = {25'd0, volume_ff};
            if (wr_en) volume_in = csr_pwdata[6:0];
         end
         default: begin
            csr_prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_rate_ff  <= OUT_RATE_RESET;
         tone_freq_ff <= TONE_FREQ_RESET;
         volume_ff    <= VOLUME_RESET;
      end else begin
         out_rate_ff  <= out_rate_in;
         tone_freq_ff <= tone_freq_in;
         volume_ff    <= volume_in;
      end
   end

   assign csr_pready = 1'b1;
   assign out_rate   = out_rate_ff;
   assign tone_freq  = tone_freq_ff;
   assign volume     = volume_ff;

endmodule

@@ sv/pstg_ctrl.sv @@
module pstg_ctrl #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pstg_pkg::pstg_cmd_type cmd
);
   import pstg_pkg::*;

   localparam int DW        = 32 + FRACTION_BITS + (FRACTION_BITS % 2);
   localparam int DIV_STEPS = DW / 2;
   localparam int CW        = $clog2(DIV_STEPS);

   pstg_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DIV_STEPS - 1)) state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/pstg_dp.sv @@
module pstg_dp #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pstg_pkg::pstg_cmd_type cmd,
   input  logic                   req_restart,
   input  logic [15:0]            out_rate,
   input  logic [15:0]            tone_freq,
   input  logic [6:0]             volume,
   output logic signed [10:0]     rsp_left_sample,
   output logic signed [10:0]     rsp_right_sample
);
   import pstg_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int DW = 32 + F + (F % 2);

   logic [15:0]     idx_ff, idx_in;
   logic [15:0]     idx_eff;
   logic            pz;
   logic            pz_ff;
   logic            more;
   logic [32:0]     more_prod;
   logic [31:0]     n_prod;
   logic [6:0]      vclamp;
   logic [16:0]     x_ff;
   logic [33:0]     amp_prod;
   logic [9:0]      amp_ff;
   logic [DW-1:0]   dv_ff;
   logic [15:0]     rem_ff;
   logic [F-1:0]    q_ff;
   logic [16:0]     r1, r2;
   logic            ge1, ge2;
   logic [15:0]     r1s, r2s;
   logic [F:0]      q2, a, om;
   logic [2*F+1:0]  m1_prod;
   logic [2*F-2:0]  m1_ff;
   logic            neg_ff;
   logic [2*F+8:0]  m2_prod;
   logic [9:0]      mag_ff;
   logic signed [10:0] res;
   logic signed [10:0] out_ff;

   assign idx_eff   = req_restart ? 16'd0 : idx_ff;
   assign pz        = (tone_freq == 16'd0) || (tone_freq > out_rate);
   assign more_prod = 33'({1'b0, idx_eff} + 17'd2) * 33'(tone_freq);
   assign more      = more_prod <= 33'(out_rate);
   assign n_prod    = 32'(idx_eff) * 32'(tone_freq);
   assign vclamp    = (volume > VOL_MAX) ? VOL_MAX : volume;
   assign amp_prod  = 34'(x_ff) * 34'(AMP_RECIP);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         if (pz || !more) idx_in = 16'd0;
         else             idx_in = idx_eff + 16'd1;
      end
   end

   assign r1  = {rem_ff, dv_ff[DW-1]};
   assign ge1 = r1 >= {1'b0, out_rate};
   assign r1s = ge1 ? 16'(r1 - {1'b0, out_rate}) : r1[15:0];
   assign r2  = {r1s, dv_ff[DW-2]};
   assign ge2 = r2 >= {1'b0, out_rate};
   assign r2s = ge2 ? 16'(r2 - {1'b0, out_rate}) : r2[15:0];

   assign q2      = {q_ff, 1'b0};
   assign a       = q_ff[F-1] ? ((F+1)'(0) - q2) : q2;
   assign om      = ((F+1)'(1) << F) - a;
   assign m1_prod = (2*F+2)'(a) * (2*F+2)'(om);
   assign m2_prod = (2*F+9)'(m1_ff) * (2*F+9)'(amp_ff);

   assign res = pz_ff  ? 11'sd0 :
                neg_ff ? $signed(11'd0 - {1'b0, mag_ff}) : $signed({1'b0, mag_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 16'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pz_ff  <= pz;
         x_ff   <= 17'(vclamp) * AMP_FULL;
         dv_ff  <= DW'(n_prod) << F;
         rem_ff <= 16'd0;
      end
      if (cmd.div_step) begin
         amp_ff <= amp_prod[AMP_SHIFT+9:AMP_SHIFT];
         dv_ff  <= dv_ff << 2;
         rem_ff <= r2s;
         q_ff   <= {q_ff[F-3:0], ge1, ge2};
      end
      if (cmd.mul1) begin
         m1_ff  <= m1_prod[2*F-2:0];
         neg_ff <= ~q_ff[F-1];
      end
      if (cmd.mul2) begin
         mag_ff <= m2_prod[2*F+7:2*F-2];
      end
      if (cmd.out_load) begin
         out_ff <= res;
      end
   end

   assign rsp_left_sample  = out_ff;
   assign rsp_right_sample = out_ff;

endmodule

@@ sv/parabolic_sine_tone_generator_top.sv @@
// Stereo tone generator: each request yields one sample pair (left equals right) of a
// parabolic sine approximation at tone_freq Hz for a stream at the configured output rate,
// scaled by volume percent (clamped to 100, full scale +/-819). Assert restart to start the
// tone from phase zero. A tone above the output rate or a zero frequency gives silence. A new
// request is accepted only in the idle state, once the previous one has finished: the phase
// is a restoring division retiring two quotient bits per cycle, followed by the MUL1 and
// MUL2 multiply states and the DONE output state, which waits while a held result is stalled.
// The result register holds a finished sample while the next request runs.
module parabolic_sine_tone_generator_top #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [10:0] rsp_left_sample,
   output logic signed [10:0] rsp_right_sample,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import pstg_pkg::*;

   pstg_cmd_type cmd;
   logic [15:0]  out_rate;
   logic [15:0]  tone_freq;
   logic [6:0]   volume;

   pstg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .out_rate    (out_rate),
      .tone_freq   (tone_freq),
      .volume      (volume)
   );

   pstg_ctrl #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   pstg_dp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_restart      (req_restart),
      .out_rate         (out_rate),
      .tone_freq        (tone_freq),
      .volume           (volume),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample)
   );

endmodule

@@ verif/tone_sample_checker.sv @@
module tone_sample_checker #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_restart,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [10:0] rsp_left_sample,
   input  logic signed [10:0] rsp_right_sample,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 mismatch_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import pstg_pkg::*;

   typedef struct {
      logic signed [10:0] left;
      logic signed [10:0] right;
   } stereo_sample_type;

   logic [15:0] rate_reg;
   logic [15:0] freq_reg;
   logic [6:0]  volume_reg;
   logic [15:0] tone_index;

   stereo_sample_type expected_samples[$];
   int errors = 0;

   assign mismatch_count = errors;

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic logic signed [10:0] predict_tone_sample(logic restart);
      logic [63:0] one;
      logic [63:0] period;
      logic [63:0] level;
      logic [63:0] phase;
      logic [63:0] depth;
      logic [63:0] magnitude;
      logic        rising;
      logic [10:0] code;
      one = 64'd1 << FRACTION_BITS;
      if (restart) begin
         tone_index = '0;
      end
      period = (freq_reg == '0) ? 64'd0 : 64'(rate_reg) / 64'(freq_reg);
      if (period == 64'd0) begin
         tone_index = '0;
         return '0;
      end
      level = 64'(AMP_FULL) * 64'((volume_reg > VOL_MAX) ? VOL_MAX : volume_reg)
              / 64'(VOL_MAX);
      phase = ((64'(tone_index) * 64'(freq_reg)) << FRACTION_BITS) / 64'(rate_reg);
      phase = phase & (one - 64'd1);
      rising = phase < (one >> 1);
      depth = rising ? 64'd2 * phase : 64'd2 * one - 64'd2 * phase;
      magnitude = (64'd4 * depth * (one - depth) * level) >> (2 * FRACTION_BITS);
      code = rising ? 11'(64'd0 - magnitude) : 11'(magnitude);
      tone_index = (64'(tone_index) + 64'd1 < period) ? tone_index + 16'd1 : 16'd0;
      return code;
   endfunction

   always @(posedge clock) begin
      stereo_sample_type want;
      if (reset) begin
         rate_reg = OUT_RATE_RESET;
         freq_reg = TONE_FREQ_RESET;
         volume_reg = VOLUME_RESET;
         tone_index = '0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected sample", rsp_left_sample, 0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_left_sample !== want.left) begin
                  report_mismatch("left_sample", rsp_left_sample, want.left);
               end
               if (rsp_right_sample !== want.right) begin
                  report_mismatch("right_sample", rsp_right_sample, want.right);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_OUT_RATE:  rate_reg = csr_pwdata[15:0];
               REG_TONE_FREQ: freq_reg = csr_pwdata[15:0];
               REG_VOLUME:    volume_reg = csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want.left = predict_tone_sample(req_restart);
            want.right = want.left;
            expected_samples.push_back(want);
         end
      end
      pending_count <= expected_samples.size();
   end

endmodule

@@ verif/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pstg_pkg::*;

   localparam int FRACTION_BITS = 16;
   localparam int PHASE_COUNT = 15;
   localparam int PHASE_ITEMS = 95;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [10:0] rsp_left_sample;
   logic signed [10:0] rsp_right_sample;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int mismatches;
   int pending;
   int idle_odds = 0;
   int stall_left = 0;

   parabolic_sine_tone_generator_top #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_sample(rsp_left_sample),
      .rsp_right_sample(rsp_right_sample),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   tone_sample_checker #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_sample(rsp_left_sample),
      .rsp_right_sample(rsp_right_sample),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_pready(csr_pready),
      .mismatch_count(mismatches),
      .pending_count(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hold the result side in bursts
   always @(posedge clock) begin
      if (reset || idle_odds == 0) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_odds) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_tone_request(logic restart);
      if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_samples_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_tone(logic [15:0] rate, logic [15:0] freq, logic [6:0] volume);
      wait_samples_drained();
      csr_write(REG_OUT_RATE, {16'($urandom()), rate});
      csr_write(REG_TONE_FREQ, {16'($urandom()), freq});
      csr_write(REG_VOLUME, {25'($urandom()), volume});
   endtask

   task automatic pick_tone_setting(int phase_num);
      int kind;
      int period;
      logic [15:0] rate;
      logic [15:0] freq;
      logic [6:0] volume;
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
         0: volume = 7'd100;
         1: volume = 7'd127;
         default: volume = 7'($urandom_range(0, 127));
      endcase
      if (kind < 2) begin
         case ($urandom_range(0, 3))
            0: rate = 16'd8000;
            1: rate = 16'd48000;
            2: rate = 16'd0;
            default: rate = 16'hFFFF;
         endcase
         case ($urandom_range(0, 4))
            0: freq = 16'd0;
            1: freq = 16'd1;
            2: freq = 16'd48000;
            3: freq = rate;
            default: freq = 16'hFFFF;
         endcase
      end else begin
         rate = 16'($urandom_range(8000, 48000));
         period = (kind < 8) ? $urandom_range(1, 40) : $urandom_range(41, 3000);
         freq = 16'(int'(rate) / period);
         if ($urandom_range(0, 3) == 0) begin
            freq = freq + 16'($urandom_range(0, 3));
         end
      end
      case (phase_num)
         0: set_tone(16'd48000, 16'd1, 7'd127);
         1: set_tone(16'd8000, 16'd8000, 7'd0);
         2: set_tone(16'hFFFF, 16'd3, 7'd100);
         3: set_tone(16'd8000, 16'hFFFF, 7'd100);
         default: set_tone(rate, freq, volume);
      endcase
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_tone_request(1'b1);
      repeat (17) send_tone_request(1'b0);
      set_tone(16'd16000, 16'd8000, 7'd100);
      send_tone_request(1'b0);
      set_tone(16'd16000, 16'd0, 7'd100);
      send_tone_request(1'b0);
      set_tone(16'd0, 16'd1000, 7'd100);
      send_tone_request(1'b1);
      set_tone(16'd8000, 16'd48000, 7'd100);
      send_tone_request(1'b0);
      set_tone(16'd48000, 16'd12000, 7'd127);
      send_tone_request(1'b1);
      send_tone_request(1'b0);
      set_tone(16'd48000, 16'd12000, 7'd0);
      send_tone_request(1'b0);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         pick_tone_setting(ph);
         case ($urandom_range(0, 2))
            0: idle_odds = 0;
            1: idle_odds = 15;
            default: idle_odds = 40;
         endcase
         if (ph == PHASE_COUNT - 1) begin
            idle_odds = 0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 5 && n == 40) begin
               wait_samples_drained();
            end
            send_tone_request($urandom_range(0, 19) == 0);
         end
      end

      req_valid <= 1'b0;
      idle_odds = 0;
      @(posedge clock);
      for (int w = 0; w < 10000 && pending != 0; w++) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
